@@ hw/rtl/hdm_pkg.sv @@
// package: constants, types and helpers for the homography distance measure
package hdm_pkg;
    localparam int PixBits      = 12;
    localparam int CoefFracBits = 24;
    localparam int CoefW        = 48;
    localparam int OutW         = 40;
    localparam int AccW         = 64;
    localparam int NumRegs      = 8;
    localparam int IdxW         = 3;

    localparam logic [AccW-1:0] WEps = AccW'((64'd1 << CoefFracBits) / 10000);
    localparam logic signed [OutW-1:0] Sentinel = 40'sd2560000000;
    localparam logic [OutW-1:0] Mask40 = {OutW{1'b1}};

    typedef enum logic [1:0] {
        ACT_PRESS   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_MOVE    = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        REG_XX = 3'd0, REG_XY = 3'd1, REG_XT = 3'd2, REG_YX = 3'd3,
        REG_YY = 3'd4, REG_YT = 3'd5, REG_WX = 3'd6, REG_WY = 3'd7
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MAC, ST_WCHK, ST_DIVX, ST_DIVY, ST_DIST,
        ST_SQ, ST_SQRT, ST_UPD, ST_OUT
    } t_state;

    // control between the top level and the serial divider
    typedef struct packed {
        logic start;
        logic neg;
    } t_div_ctl;

    function automatic logic signed [AccW-1:0] sat_add(
        input logic signed [AccW-1:0] a, input logic signed [AccW-1:0] b);
        logic signed [AccW-1:0] s;
        s = a + b;
        if (a[AccW-1] == b[AccW-1] && s[AccW-1] != a[AccW-1])
            return a[AccW-1] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
        return s;
    endfunction
endpackage

@@ hw/rtl/homography_distance_measure.sv @@
// top level: pointer event mapping through a homography with distance meter
// One event is in flight at a time. Its steps, in order: six serial products
// (one pixel bit a cycle, plus one add each), two bit-serial divider runs, which
// are skipped when the far test holds, two serial squares with their load steps,
// the 41-step square root, then the update and output steps. The next word is
// taken in the cycle after the result is loaded. A result waiting in the output
// register does not hold off the input; the following event waits at its last step
// until that register is free.
module homography_distance_measure (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // action[1:0], pix_x[13:2], pix_y[25:14]
    input  logic        s_axis_tuser,   // curve_mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [159:0] m_axis_tdata,  // world_x, world_y, segment_dist, total_length
    output logic [1:0]  m_axis_tuser,   // far_point, measure_valid
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);
    import hdm_pkg::*;

    t_state r_state, n_state;
    logic signed [CoefW-1:0] r_coef [NumRegs];
    t_action r_act;
    logic [PixBits-1:0] r_px, r_py;
    logic r_curve;
    logic signed [AccW-1:0] r_nx, r_ny, r_nw;
    logic signed [OutW-1:0] r_anc_x, r_anc_y, r_wx, r_wy;
    logic [OutW-1:0] r_total, r_seg;
    logic r_held, r_far;
    logic [2:0] r_term;
    logic [$clog2(PixBits+1)-1:0] r_bit;
    logic [AccW-1:0] r_acc;
    logic [AccW-1:0] r_mc;
    logic [PixBits-1:0] r_mp;
    logic [81:0] r_s;
    logic [OutW:0] r_dym, r_sa, r_sm;
    logic [81:0] r_sqacc;
    logic r_sqsel;
    logic [5:0] r_cnt;
    logic [OutW-1:0] r_root;
    logic [83:0] r_rem;
    logic [81:0] r_srad;
    logic r_out_v;
    logic [159:0] r_out_d;
    logic [1:0] r_out_u;
    t_div_ctl w_dctl;
    logic w_ddone;
    logic signed [OutW-1:0] w_dquo;
    logic [AccW-1:0] w_wmag, w_dnum;
    logic signed [OutW:0] w_dx, w_dy;
    logic [83:0] w_trial;
    logic [OutW:0] w_tsum;
    logic [81:0] w_ssum;

    assign o_cfg_ready = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata = r_out_d;
    assign m_axis_tuser = r_out_u;
    assign w_wmag = r_nw[AccW-1] ? AccW'(-r_nw) : AccW'(r_nw);
    assign w_dnum = (r_state == ST_WCHK) ?
        (r_nx[AccW-1] ? AccW'(-r_nx) : AccW'(r_nx)) :
        (r_ny[AccW-1] ? AccW'(-r_ny) : AccW'(r_ny));
    assign w_dx = {r_wx[OutW-1], r_wx} - {r_anc_x[OutW-1], r_anc_x};
    assign w_dy = {r_wy[OutW-1], r_wy} - {r_anc_y[OutW-1], r_anc_y};
    assign w_trial = {r_rem[81:0], r_srad[81:80]} - {42'd0, r_root, 2'b01};
    assign w_tsum = {1'b0, r_total} + {1'b0, r_seg};
    assign w_ssum = r_s + r_sqacc;

    hdm_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_dctl),
        .i_num(w_dnum), .i_den(w_wmag), .o_done(w_ddone), .o_quo(w_dquo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        w_dctl  = '0;
        unique case (r_state)
            ST_IDLE: if (s_axis_tvalid && s_axis_tready) n_state = ST_MAC;
            ST_MAC:  if (r_term == 3'd5 && r_bit == '0) n_state = ST_WCHK;
            ST_WCHK: begin
                if (w_wmag <= WEps) n_state = ST_DIST;
                else begin
                    n_state = ST_DIVX;
                    w_dctl.start = 1'b1;
                    w_dctl.neg = r_nx[AccW-1] ^ r_nw[AccW-1];
                end
            end
            ST_DIVX: begin
                if (w_ddone) begin
                    n_state = ST_DIVY;
                    w_dctl.start = 1'b1;
                    w_dctl.neg = r_ny[AccW-1] ^ r_nw[AccW-1];
                end
            end
            ST_DIVY: if (w_ddone) n_state = ST_DIST;
            ST_DIST: n_state = ST_SQ;
            ST_SQ:   if (r_sqsel && r_cnt == '0) n_state = ST_SQRT;
            ST_SQRT: if (r_cnt == '0) n_state = ST_UPD;
            ST_UPD:  n_state = ST_OUT;
            ST_OUT:  if (!r_out_v) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[REG_XX] <= CoefW'(64'd1 << CoefFracBits);
            r_coef[REG_XY] <= '0; r_coef[REG_XT] <= '0; r_coef[REG_YX] <= '0;
            r_coef[REG_YY] <= CoefW'(64'd1 << CoefFracBits);
            r_coef[REG_YT] <= '0; r_coef[REG_WX] <= '0; r_coef[REG_WY] <= '0;
            r_anc_x <= '0; r_anc_y <= '0; r_total <= '0; r_held <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_cfg_valid) r_coef[i_cfg_index] <= i_cfg_data;
            if (m_axis_tvalid && m_axis_tready) r_out_v <= 1'b0;
            unique case (r_state)
                ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_act   <= t_action'(s_axis_tdata[1:0]);
                    r_px    <= s_axis_tdata[13:2];
                    r_py    <= s_axis_tdata[25:14];
                    r_curve <= s_axis_tuser;
                    r_nx <= r_coef[REG_XT];
                    r_ny <= r_coef[REG_YT];
                    r_nw <= AccW'(64'd1 << CoefFracBits);
                    r_term <= '0;
                    r_bit <= ($clog2(PixBits+1))'(PixBits);
                    r_acc <= '0;
                    r_mc <= AccW'(r_coef[REG_XX]);
                    r_mp <= s_axis_tdata[13:2];
                end
                ST_MAC: begin
                    if (r_bit != '0) begin
                        r_acc <= {r_acc[AccW-2:0], 1'b0} + (r_mp[PixBits-1] ? r_mc : '0);
                        r_mp  <= {r_mp[PixBits-2:0], 1'b0};
                        r_bit <= r_bit - 1'b1;
                    end else begin
                        unique case (r_term)
                            3'd0, 3'd1: r_nx <= sat_add(r_nx, r_acc);
                            3'd2, 3'd3: r_ny <= sat_add(r_ny, r_acc);
                            default:    r_nw <= sat_add(r_nw, r_acc);
                        endcase
                        r_term <= r_term + 1'b1;
                        r_bit <= ($clog2(PixBits+1))'(PixBits);
                        r_acc <= '0;
                        unique case (r_term)
                            3'd0: begin r_mc <= AccW'(r_coef[REG_XY]); r_mp <= r_py; end
                            3'd1: begin r_mc <= AccW'(r_coef[REG_YX]); r_mp <= r_px; end
                            3'd2: begin r_mc <= AccW'(r_coef[REG_YY]); r_mp <= r_py; end
                            3'd3: begin r_mc <= AccW'(r_coef[REG_WX]); r_mp <= r_px; end
                            default: begin r_mc <= AccW'(r_coef[REG_WY]); r_mp <= r_py; end
                        endcase
                    end
                end
                ST_WCHK: begin
                    r_far <= (w_wmag <= WEps);
                    r_wx <= Sentinel; r_wy <= Sentinel;
                end
                ST_DIVX: if (w_ddone) r_wx <= w_dquo;
                ST_DIVY: if (w_ddone) r_wy <= w_dquo;
                ST_DIST: begin
                    r_dym <= w_dy[OutW] ? -w_dy : w_dy;
                    r_sa  <= w_dx[OutW] ? -w_dx : w_dx;
                    r_sm  <= w_dx[OutW] ? -w_dx : w_dx;
                    r_sqacc <= '0; r_sqsel <= 1'b0; r_cnt <= 6'd41;
                end
                ST_SQ: begin
                    if (r_cnt != '0) begin
                        r_sqacc <= {r_sqacc[80:0], 1'b0} + (r_sm[OutW] ? 82'(r_sa) : '0);
                        r_sm <= {r_sm[OutW-1:0], 1'b0};
                        r_cnt <= r_cnt - 1'b1;
                    end else if (!r_sqsel) begin
                        r_s <= r_sqacc;
                        r_sqacc <= '0; r_sqsel <= 1'b1; r_cnt <= 6'd41;
                        r_sa <= r_dym; r_sm <= r_dym;
                    end else begin
                        r_srad <= w_ssum;
                        r_rem <= '0; r_root <= '0; r_cnt <= 6'd41;
                    end
                end
                ST_SQRT: if (r_cnt != '0) begin
                    r_cnt <= r_cnt - 1'b1;
                    r_srad <= {r_srad[79:0], 2'b00};
                    if (!w_trial[83]) begin
                        r_rem <= w_trial; r_root <= {r_root[OutW-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[81:0], r_srad[81:80]};
                        r_root <= {r_root[OutW-2:0], 1'b0};
                    end
                end
                ST_UPD: begin
                    r_seg <= (w_ssum[81:80] != 2'b00) ? Mask40 : r_root;
                end
                ST_OUT: if (!r_out_v) begin
                    unique case (r_act)
                        ACT_PRESS: begin
                            r_anc_x <= r_wx; r_anc_y <= r_wy; r_held <= 1'b1;
                            if (r_curve) r_total <= '0;
                        end
                        ACT_RELEASE: begin
                            r_held <= 1'b0;
                            if (r_curve) r_total <= w_tsum[OutW] ? Mask40 : w_tsum[OutW-1:0];
                        end
                        ACT_MOVE: if (r_held && r_curve) begin
                            r_total <= w_tsum[OutW] ? Mask40 : w_tsum[OutW-1:0];
                            r_anc_x <= r_wx; r_anc_y <= r_wy;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
            if (r_state == ST_OUT && !r_out_v) begin
                logic mv;
                logic [OutW-1:0] nt;
                mv = (r_act == ACT_RELEASE) || (r_act == ACT_MOVE && r_held && r_curve);
                nt = r_total;
                if (r_act == ACT_PRESS && r_curve) nt = '0;
                else if (mv && r_curve) nt = w_tsum[OutW] ? Mask40 : w_tsum[OutW-1:0];
                r_out_v <= 1'b1;
                r_out_d <= {nt, mv ? r_seg : {OutW{1'b0}}, r_wy, r_wx};
                r_out_u <= {mv, r_far};
            end
        end
    end
endmodule

@@ hw/rtl/hdm_div.sv @@
// restoring bit-serial divider: q8 quotient of |num|/den, saturated, signed
module hdm_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hdm_pkg::t_div_ctl            i_ctl,
    input  logic [hdm_pkg::AccW-1:0]     i_num,
    input  logic [hdm_pkg::AccW-1:0]     i_den,
    output logic                         o_done,
    output logic signed [hdm_pkg::OutW-1:0] o_quo
);
    import hdm_pkg::*;

    localparam int Steps = AccW + 8;
    localparam int CntW  = $clog2(Steps + 1);

    logic [AccW-1:0] r_den;
    logic [AccW:0]   r_rem, n_rem;
    logic [AccW-1:0] r_num;
    logic [AccW+7:0] r_q;
    logic [CntW-1:0] r_cnt;
    logic            r_busy, r_neg, r_done;
    logic [AccW:0]   w_sh;

    always_comb begin
        w_sh  = {r_rem[AccW-1:0], r_num[AccW-1]};
        n_rem = (w_sh >= {1'b0, r_den}) ? w_sh - {1'b0, r_den} : w_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(Steps);
                r_neg  <= i_ctl.neg;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_num <= {r_num[AccW-2:0], 1'b0};
                r_q   <= {r_q[AccW+6:0], w_sh >= {1'b0, r_den}};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_done = r_done;
        if (r_q[AccW+7:39] != '0)
            o_quo = r_neg ? {1'b1, {(OutW-1){1'b0}}} : {1'b0, {(OutW-1){1'b1}}};
        else
            o_quo = r_neg ? -$signed({1'b0, r_q[38:0]}) : $signed({1'b0, r_q[38:0]});
    end
endmodule

@@ hw/rtl/hdm_checker.sv @@
// port-level checker for the homography distance measure, bound to the top
module hdm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [159:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word dropped");
    a_noseg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[119:80] == '0)
        else $error("distance without measure");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word taken while busy");
    a_far: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[39:0] == 40'd2560000000)
        else $error("far point without sentinel");
endmodule

bind homography_distance_measure hdm_checker u_hdm_checker (.*);

@@ test/tb_homography_distance_measure.sv @@
// testbench: homography distance measure checked against a built-in predictor
module tb_homography_distance_measure;
    timeunit 1ns;
    timeprecision 1ps;
    import hdm_pkg::*;

    typedef struct {
        logic signed [39:0] wx;
        logic signed [39:0] wy;
        logic [39:0]        seg;
        logic [39:0]        tot;
        logic               far;
        logic               mv;
    } t_res;

    typedef struct {
        t_action     act;
        logic [11:0] x;
        logic [11:0] y;
        logic        curve;
        logic        typed;
        t_res        res;
    } t_dir_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [159:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index;
    logic [47:0]  i_cfg_data;

    homography_distance_measure dut (.*);

    // predictor state
    longint      coef [8];
    longint      anc_x, anc_y;
    logic [39:0] curve_len;
    logic        held;

    t_res        pending_events [$];
    int          errors;
    int          results_seen;
    bit          quiet;
    bit          far_bias;
    bit          long_hold_done;
    t_dir_row    dir_rows [11];

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic longint add_sat(input longint a, input longint b);
        longint s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            return a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        return s;
    endfunction

    function automatic logic [63:0] abs64(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [39:0] div_q8(input longint num, input logic [63:0] dm,
                                                 input logic neg);
        logic [63:0] a;
        logic [71:0] q;
        a = abs64(num);
        if (a / dm >= 64'd2147483648)
            return neg ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
        q = {a, 8'b0} / {8'b0, dm};
        return neg ? -q[39:0] : q[39:0];
    endfunction

    function automatic logic [39:0] seg_length(input longint x, input longint y);
        logic [63:0]  dx, dy;
        logic [127:0] s, c;
        logic [39:0]  r;
        dx = abs64(x - anc_x);
        dy = abs64(y - anc_y);
        if (dx > 64'(Mask40) || dy > 64'(Mask40))
            return Mask40;
        s = {64'b0, dx} * {64'b0, dx} + {64'b0, dy} * {64'b0, dy};
        if (s >= (128'd1 << 80))
            return Mask40;
        r = '0;
        for (int b = 39; b >= 0; b--) begin
            c = {88'b0, r | (40'd1 << b)};
            if (c * c <= s)
                r = r | (40'd1 << b);
        end
        return r;
    endfunction

    function automatic t_res map_and_measure(input t_action act, input logic [11:0] px,
                                             input logic [11:0] py, input logic curve);
        t_res        r;
        longint      nx, ny, w, x, y;
        logic [63:0] wm;
        logic [40:0] sum;
        nx = add_sat(add_sat(coef[REG_XX] * longint'(px), coef[REG_XY] * longint'(py)),
                     coef[REG_XT]);
        ny = add_sat(add_sat(coef[REG_YX] * longint'(px), coef[REG_YY] * longint'(py)),
                     coef[REG_YT]);
        w = add_sat(add_sat(coef[REG_WX] * longint'(px), coef[REG_WY] * longint'(py)),
                    longint'(1) << CoefFracBits);
        wm = abs64(w);
        r.far = (wm <= WEps);
        if (r.far) begin
            r.wx = Sentinel;
            r.wy = Sentinel;
        end else begin
            r.wx = div_q8(nx, wm, (nx < 0) != (w < 0));
            r.wy = div_q8(ny, wm, (ny < 0) != (w < 0));
        end
        x = longint'(r.wx);
        y = longint'(r.wy);
        r.seg = '0;
        r.mv = 1'b0;
        if (act == ACT_PRESS) begin
            anc_x = x;
            anc_y = y;
            if (curve)
                curve_len = '0;
            held = 1'b1;
        end else if (act == ACT_RELEASE) begin
            r.seg = seg_length(x, y);
            r.mv = 1'b1;
            if (curve) begin
                sum = {1'b0, curve_len} + {1'b0, r.seg};
                curve_len = sum[40] ? Mask40 : sum[39:0];
            end
            held = 1'b0;
        end else if (act == ACT_MOVE && held && curve) begin
            r.seg = seg_length(x, y);
            r.mv = 1'b1;
            sum = {1'b0, curve_len} + {1'b0, r.seg};
            curve_len = sum[40] ? Mask40 : sum[39:0];
            anc_x = x;
            anc_y = y;
        end
        r.tot = curve_len;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [39:0] got,
                                   input logic [39:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, field, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_events.size() == 0) begin
                report_mismatch("unexpected word", 40'd0, 40'd0);
            end else begin
                want = pending_events.pop_front();
                if (m_axis_tdata[39:0] !== want.wx)
                    report_mismatch("world_x", m_axis_tdata[39:0], want.wx);
                if (m_axis_tdata[79:40] !== want.wy)
                    report_mismatch("world_y", m_axis_tdata[79:40], want.wy);
                if (m_axis_tdata[119:80] !== want.seg)
                    report_mismatch("segment_dist", m_axis_tdata[119:80], want.seg);
                if (m_axis_tdata[159:120] !== want.tot)
                    report_mismatch("total_length", m_axis_tdata[159:120], want.tot);
                if (m_axis_tuser[0] !== want.far)
                    report_mismatch("far_point", 40'(m_axis_tuser[0]), 40'(want.far));
                if (m_axis_tuser[1] !== want.mv)
                    report_mismatch("measure_valid", 40'(m_axis_tuser[1]), 40'(want.mv));
            end
        end
    end

    // receiver side: random stalls and one long hold-off
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!long_hold_done && results_seen >= 30) begin
                long_hold_done = 1'b1;
                m_axis_tready = 1'b0;
                repeat (2000) @(negedge i_clk);
                m_axis_tready = 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(0, 9)) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    task automatic send_event(input t_action act, input logic [11:0] px, input logic [11:0] py,
                              input logic curve, input logic typed, input t_res typed_res);
        t_res r;
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {6'b0, py, px, act};
        s_axis_tuser = curve;
        do @(posedge i_clk); while (!s_axis_tready);
        r = map_and_measure(act, px, py, curve);
        if (typed)
            r = typed_res;
        pending_events.insert(pending_events.size(), r);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
    endtask

    task automatic write_coef(input t_reg_idx idx, input logic [47:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        coef[idx] = longint'($signed(val));
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain;
        s_axis_tvalid = 1'b0;
        while (pending_events.size() != 0)
            @(negedge i_clk);
        repeat (400) @(negedge i_clk);
    endtask

    function automatic logic [47:0] rand48;
        return 48'({$urandom, $urandom});
    endfunction

    function automatic logic [11:0] rand_pix;
        if (far_bias && $urandom_range(0, 2) == 0)
            return 12'd256;
        return 12'($urandom_range(0, 4095));
    endfunction

    task automatic gestures(input int n);
        t_res        none;
        int          sent;
        int          moves;
        logic        c;
        logic [11:0] px, py;
        none = '{default: '0};
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 6) == 0) begin
                send_event(t_action'($urandom_range(0, 3)), rand_pix(), rand_pix(),
                           1'($urandom), 1'b0, none);
                sent++;
            end else begin
                c = 1'($urandom);
                px = rand_pix();
                py = rand_pix();
                send_event(ACT_PRESS, px, py, c, 1'b0, none);
                moves = $urandom_range(0, 5);
                repeat (moves) begin
                    if ($urandom_range(0, 3) == 0) begin
                        px = rand_pix();
                        py = rand_pix();
                    end else begin
                        px = px + 12'($urandom_range(0, 128) - 64);
                        py = py + 12'($urandom_range(0, 128) - 64);
                    end
                    send_event(ACT_MOVE, px, py, ($urandom_range(0, 9) == 0) ? !c : c,
                               1'b0, none);
                end
                send_event(ACT_RELEASE, rand_pix(), rand_pix(), c, 1'b0, none);
                sent += moves + 2;
            end
        end
    endtask

    initial begin
        t_res none;
        none = '{default: '0};
        errors = 0;
        results_seen = 0;
        quiet = 1'b0;
        far_bias = 1'b0;
        long_hold_done = 1'b0;
        coef = '{longint'(1) << 24, 0, 0, 0, longint'(1) << 24, 0, 0, 0};
        anc_x = 0;
        anc_y = 0;
        curve_len = '0;
        held = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_XX;
        i_cfg_data = '0;

        dir_rows[0]  = '{ACT_PRESS,   12'd0,    12'd0,    1'b0, 1'b1,
                         '{40'd0, 40'd0, 40'd0, 40'd0, 1'b0, 1'b0}};
        dir_rows[1]  = '{ACT_RELEASE, 12'd3,    12'd4,    1'b0, 1'b1,
                         '{40'd768, 40'd1024, 40'd1280, 40'd0, 1'b0, 1'b1}};
        dir_rows[2]  = '{ACT_RELEASE, 12'd4095, 12'd4095, 1'b0, 1'b0, none};
        dir_rows[3]  = '{ACT_PRESS,   12'd10,   12'd10,   1'b1, 1'b1,
                         '{40'd2560, 40'd2560, 40'd0, 40'd0, 1'b0, 1'b0}};
        dir_rows[4]  = '{ACT_MOVE,    12'd13,   12'd14,   1'b1, 1'b1,
                         '{40'd3328, 40'd3584, 40'd1280, 40'd1280, 1'b0, 1'b1}};
        dir_rows[5]  = '{ACT_MOVE,    12'd13,   12'd14,   1'b0, 1'b1,
                         '{40'd3328, 40'd3584, 40'd0, 40'd1280, 1'b0, 1'b0}};
        dir_rows[6]  = '{ACT_RELEASE, 12'd16,   12'd18,   1'b1, 1'b1,
                         '{40'd4096, 40'd4608, 40'd1280, 40'd2560, 1'b0, 1'b1}};
        dir_rows[7]  = '{ACT_MOVE,    12'd0,    12'd0,    1'b1, 1'b1,
                         '{40'd0, 40'd0, 40'd0, 40'd2560, 1'b0, 1'b0}};
        dir_rows[8]  = '{ACT_NONE,    12'd1,    12'd2,    1'b1, 1'b1,
                         '{40'd256, 40'd512, 40'd0, 40'd2560, 1'b0, 1'b0}};
        dir_rows[9]  = '{ACT_PRESS,   12'd4095, 12'd0,    1'b0, 1'b0, none};
        dir_rows[10] = '{ACT_RELEASE, 12'd0,    12'd4095, 1'b0, 1'b0, none};

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i])
            send_event(dir_rows[i].act, dir_rows[i].x, dir_rows[i].y, dir_rows[i].curve,
                       dir_rows[i].typed, dir_rows[i].res);
        gestures(60);

        // all coefficients at the positive extreme
        drain();
        for (int i = 0; i < 8; i++)
            write_coef(t_reg_idx'(i), {1'b0, {47{1'b1}}});
        gestures(60);

        // all coefficients at the negative extreme
        drain();
        for (int i = 0; i < 8; i++)
            write_coef(t_reg_idx'(i), {1'b1, 47'b0});
        gestures(60);

        // w crosses zero at pixel x 256
        drain();
        far_bias = 1'b1;
        write_coef(REG_XX, 48'd1 << 24);
        write_coef(REG_XY, 48'd0);
        write_coef(REG_XT, 48'd0);
        write_coef(REG_YX, 48'd0);
        write_coef(REG_YY, 48'd1 << 24);
        write_coef(REG_YT, 48'd0);
        write_coef(REG_WX, -48'sd65536);
        write_coef(REG_WY, 48'd0);
        gestures(70);
        far_bias = 1'b0;

        // moderate random ratios with mild perspective
        drain();
        for (int i = 0; i < 6; i++)
            write_coef(t_reg_idx'(i), 48'(longint'($signed(27'($urandom)))));
        write_coef(REG_WX, 48'(longint'($signed(13'($urandom)))));
        write_coef(REG_WY, 48'(longint'($signed(13'($urandom)))));
        gestures(70);

        // full range random coefficients
        drain();
        for (int i = 0; i < 8; i++)
            write_coef(t_reg_idx'(i), rand48());
        gestures(60);

        // x scale 0.5 and y scale 1.5 with an offset, no idling
        drain();
        quiet = 1'b1;
        for (int i = 0; i < 8; i++)
            write_coef(t_reg_idx'(i), 48'd0);
        write_coef(REG_XX, 48'd1 << 23);
        write_coef(REG_YY, 48'd3 << 23);
        write_coef(REG_XT, 48'd5 << 24);
        gestures(60);

        s_axis_tvalid = 1'b0;
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

@@ homography_distance_measure.f @@
hw/rtl/hdm_pkg.sv
hw/rtl/hdm_div.sv
hw/rtl/homography_distance_measure.sv
hw/rtl/hdm_checker.sv
test/tb_homography_distance_measure.sv
